FILE: hw/rtl/mtenc_pkg.sv
// Shared types and constants for the multiturn encoder unwrapper.
// Used by every module in hw/rtl; has no dependencies of its own.
package mtenc_pkg;

  // Ring depth is a power of two so that the average is a shift.
  localparam int RING_LOG2  = 3;
  localparam int RING_DEPTH = 1 << RING_LOG2;

  localparam int READ_W  = 13;
  localparam int DIFF_W  = READ_W + 2;
  localparam int RATE_W  = 14;
  localparam int SUM_W   = RATE_W + RING_LOG2;
  localparam int TURN_W  = 24;
  localparam int COUNT_W = TURN_W + READ_W;
  localparam int REL_W   = COUNT_W + 1;
  localparam int SCALE_W = 16;
  localparam int PROD_W  = REL_W + SCALE_W + 1;
  localparam int ANGLE_W = 64;

  localparam int HALF_REV = 4096;
  localparam int FULL_REV = 8192;
  localparam int TURN_MAX = 8388607;

  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(80);

  localparam logic signed [DIFF_W-1:0] HALF_POS = DIFF_W'(HALF_REV);
  localparam logic signed [DIFF_W-1:0] HALF_NEG = DIFF_W'(-HALF_REV);
  localparam logic signed [DIFF_W-1:0] FULL_D   = DIFF_W'(FULL_REV);
  localparam logic signed [TURN_W-1:0] TURN_POS = TURN_W'(TURN_MAX);
  localparam logic signed [TURN_W-1:0] TURN_NEG = TURN_W'(-TURN_MAX);

  typedef enum logic {
    CMD_CAPTURE = 1'b0,
    CMD_SAMPLE  = 1'b1
  } cmd_e;

  typedef logic [RING_LOG2-1:0] slot_t;

  // Pipeline control from the top level.
  typedef struct packed {
    logic adv;   // all stages move
    logic load;  // a word enters stage 1
    logic busy;  // stage 1 holds a word
  } pipe_ctl_t;

  typedef struct packed {
    logic              re;
    slot_t             addr;
  } ring_rd_t;

  typedef struct packed {
    logic              we;
    slot_t             addr;
    logic [RATE_W-1:0] data;
  } ring_wr_t;

endpackage

FILE: hw/rtl/multiturn_encoder_unwrap_rate_avg_core.sv
// Top level of the multiturn encoder unwrapper with rate average.
// Instantiates mtenc_ring, mtenc_unwrap and mtenc_scale; uses mtenc_pkg.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  command_i, raw_angle_i
//   out      output     out_valid_o / out_stall_i
//                         continuous_count_o, angle_q16_o, step_rate_o,
//                         average_rate_o, turns_o
//   cfg      input      cfg_we_i                cfg_wdata_i (angle_scale)
//
// One word per cycle while the output word is not stalled; each word passes
// through the ring read, unwrap and ring write-back, then the angle multiply.
// The ring read for the next word goes to the following slot while the
// current word writes its own, so back-to-back words never touch one entry.
// All stages hold while the output word is stalled; in_stall_o follows.
// Reset clears the state and the ring valid bits at once; no clearing pass.
module multiturn_encoder_unwrap_rate_avg_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                command_i,
  input  logic [mtenc_pkg::READ_W-1:0]        raw_angle_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [mtenc_pkg::COUNT_W-1:0] continuous_count_o,
  output logic signed [mtenc_pkg::ANGLE_W-1:0] angle_q16_o,
  output logic signed [mtenc_pkg::RATE_W-1:0]  step_rate_o,
  output logic signed [mtenc_pkg::RATE_W-1:0]  average_rate_o,
  output logic signed [mtenc_pkg::TURN_W-1:0]  turns_o,
  input  logic                                cfg_we_i,
  input  logic [mtenc_pkg::SCALE_W-1:0]       cfg_wdata_i
);

  logic                         adv;
  logic                         acc;
  logic                         v1_q, v2_q, v3_q;
  mtenc_pkg::slot_t             ptr_q, ptr_d;
  logic [mtenc_pkg::SCALE_W-1:0] scale_q;
  mtenc_pkg::cmd_e              cmd;
  mtenc_pkg::pipe_ctl_t         ctl;
  mtenc_pkg::ring_rd_t          rd;
  mtenc_pkg::ring_wr_t          wr;
  logic [mtenc_pkg::RATE_W-1:0] old_rate;

  logic [mtenc_pkg::COUNT_W-1:0]      s2_count;
  logic signed [mtenc_pkg::REL_W-1:0] s2_rel;
  logic [mtenc_pkg::RATE_W-1:0]       s2_rate;
  logic [mtenc_pkg::RATE_W-1:0]       s2_avg;
  logic [mtenc_pkg::TURN_W-1:0]       s2_turns;
  logic [mtenc_pkg::COUNT_W-1:0]      o_count;
  logic [mtenc_pkg::ANGLE_W-1:0]      o_angle;
  logic [mtenc_pkg::RATE_W-1:0]       o_rate;
  logic [mtenc_pkg::RATE_W-1:0]       o_avg;
  logic [mtenc_pkg::TURN_W-1:0]       o_turns;

  assign adv        = !(v3_q && out_stall_i);
  assign in_stall_o = !adv;
  assign acc        = in_valid_i && adv;
  assign cmd        = mtenc_pkg::cmd_e'(command_i);

  assign ctl.adv  = adv;
  assign ctl.load = acc;
  assign ctl.busy = v1_q;

  assign rd.re   = acc;
  assign rd.addr = ptr_q;

  // advance the ring slot only on samples
  always_comb begin
    ptr_d = ptr_q;
    if (acc && cmd == mtenc_pkg::CMD_SAMPLE) begin
      ptr_d = (ptr_q == mtenc_pkg::slot_t'(mtenc_pkg::RING_DEPTH - 1))
            ? '0 : ptr_q + mtenc_pkg::slot_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      ptr_q   <= '0;
      scale_q <= mtenc_pkg::SCALE_RST;
    end else begin
      if (adv) begin
        v1_q <= acc;
        v2_q <= v1_q;
        v3_q <= v2_q;
      end
      ptr_q <= ptr_d;
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
    end
  end

  mtenc_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (rd),
    .wr_i      (wr),
    .rd_data_o (old_rate)
  );

  mtenc_unwrap u_unwrap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .command_i   (cmd),
    .raw_angle_i (raw_angle_i),
    .slot_i      (ptr_q),
    .old_rate_i  (old_rate),
    .wr_o        (wr),
    .count_o     (s2_count),
    .rel_o       (s2_rel),
    .rate_o      (s2_rate),
    .avg_o       (s2_avg),
    .turns_o     (s2_turns)
  );

  mtenc_scale u_scale (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .rel_i   (s2_rel),
    .scale_i (scale_q),
    .count_i (s2_count),
    .rate_i  (s2_rate),
    .avg_i   (s2_avg),
    .turns_i (s2_turns),
    .count_o (o_count),
    .angle_o (o_angle),
    .rate_o  (o_rate),
    .avg_o   (o_avg),
    .turns_o (o_turns)
  );

  assign out_valid_o        = v3_q;
  assign continuous_count_o = $signed(o_count);
  assign angle_q16_o        = $signed(o_angle);
  assign step_rate_o        = $signed(o_rate);
  assign average_rate_o     = $signed(o_avg);
  assign turns_o            = $signed(o_turns);

endmodule

FILE: hw/rtl/mtenc_ring.sv
// Rate ring storage: one write port, one registered read port.
// Entries read as zero until first written. Depends on mtenc_pkg.
module mtenc_ring (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mtenc_pkg::ring_rd_t              rd_i,
  input  mtenc_pkg::ring_wr_t              wr_i,
  output logic [mtenc_pkg::RATE_W-1:0]     rd_data_o
);

  logic [mtenc_pkg::RATE_W-1:0]     mem_q [mtenc_pkg::RING_DEPTH];
  logic [mtenc_pkg::RING_DEPTH-1:0] vld_q;
  logic [mtenc_pkg::RATE_W-1:0]     rd_data_q;
  logic                             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.re) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.re) begin
        rd_vld_q <= vld_q[rd_i.addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

FILE: hw/rtl/mtenc_unwrap.sv
// Unwrap stage: holds last reading, bias, turn count and rate sum, and
// writes each new rate back to the ring. Depends on mtenc_pkg.
module mtenc_unwrap (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  mtenc_pkg::pipe_ctl_t                   ctl_i,
  input  mtenc_pkg::cmd_e                        command_i,
  input  logic [mtenc_pkg::READ_W-1:0]           raw_angle_i,
  input  mtenc_pkg::slot_t                       slot_i,
  input  logic [mtenc_pkg::RATE_W-1:0]           old_rate_i,
  output mtenc_pkg::ring_wr_t                    wr_o,
  output logic [mtenc_pkg::COUNT_W-1:0]          count_o,
  output logic signed [mtenc_pkg::REL_W-1:0]     rel_o,
  output logic [mtenc_pkg::RATE_W-1:0]           rate_o,
  output logic [mtenc_pkg::RATE_W-1:0]           avg_o,
  output logic [mtenc_pkg::TURN_W-1:0]           turns_o
);

  // stage 1 word
  mtenc_pkg::cmd_e                  cmd_q;
  logic [mtenc_pkg::READ_W-1:0]     read_q;
  mtenc_pkg::slot_t                 slot_q;

  // unwrap state
  logic [mtenc_pkg::READ_W-1:0]        last_q, last_d;
  logic [mtenc_pkg::READ_W-1:0]        bias_q, bias_d;
  logic signed [mtenc_pkg::TURN_W-1:0] turns_q, turns_d;
  logic signed [mtenc_pkg::SUM_W-1:0]  sum_q, sum_d;

  // stage 2 word
  logic [mtenc_pkg::COUNT_W-1:0]       count_q;
  logic signed [mtenc_pkg::REL_W-1:0]  rel_q;
  logic [mtenc_pkg::RATE_W-1:0]        rate_q;
  logic [mtenc_pkg::RATE_W-1:0]        avg_q;
  logic [mtenc_pkg::TURN_W-1:0]        turn_out_q;

  logic                                is_sample;
  logic signed [mtenc_pkg::DIFF_W-1:0] diff;
  logic signed [mtenc_pkg::DIFF_W-1:0] rate_wide;
  logic [mtenc_pkg::RATE_W-1:0]        rate;
  logic signed [mtenc_pkg::SUM_W-1:0]  sum_new;
  logic signed [mtenc_pkg::SUM_W-1:0]  sum_adj;
  logic signed [mtenc_pkg::SUM_W-1:0]  avg_full;
  logic [mtenc_pkg::COUNT_W-1:0]       count;
  logic signed [mtenc_pkg::REL_W-1:0]  rel;
  logic                                step;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= command_i;
      read_q <= raw_angle_i;
      slot_q <= slot_i;
    end
  end

  always_comb begin
    is_sample = (cmd_q == mtenc_pkg::CMD_SAMPLE);
    diff = $signed({2'b00, read_q}) - $signed({2'b00, last_q});

    turns_d = turns_q;
    if (diff < mtenc_pkg::HALF_NEG) begin
      rate_wide = diff + mtenc_pkg::FULL_D;
      if (is_sample && turns_q != mtenc_pkg::TURN_POS) begin
        turns_d = turns_q + mtenc_pkg::TURN_W'(1);
      end
    end else if (diff > mtenc_pkg::HALF_POS) begin
      rate_wide = diff - mtenc_pkg::FULL_D;
      if (is_sample && turns_q != mtenc_pkg::TURN_NEG) begin
        turns_d = turns_q - mtenc_pkg::TURN_W'(1);
      end
    end else begin
      rate_wide = diff;
    end
    rate = rate_wide[mtenc_pkg::RATE_W-1:0];

    // drop the oldest rate, add the new one
    sum_new = sum_q
            - $signed({{(mtenc_pkg::SUM_W-mtenc_pkg::RATE_W){old_rate_i[mtenc_pkg::RATE_W-1]}},
                       old_rate_i})
            + $signed({{(mtenc_pkg::SUM_W-mtenc_pkg::RATE_W){rate[mtenc_pkg::RATE_W-1]}},
                       rate});

    last_d = read_q;
    bias_d = is_sample ? bias_q : read_q;
    sum_d  = is_sample ? sum_new : sum_q;

    // truncate toward zero: bias negative sums before the shift
    sum_adj  = sum_d + (sum_d[mtenc_pkg::SUM_W-1]
                        ? mtenc_pkg::SUM_W'(mtenc_pkg::RING_DEPTH - 1)
                        : '0);
    avg_full = sum_adj >>> mtenc_pkg::RING_LOG2;

    count = {turns_d, read_q};
    rel   = $signed({count[mtenc_pkg::COUNT_W-1], count})
          - $signed({{(mtenc_pkg::REL_W-mtenc_pkg::READ_W){1'b0}}, bias_d});
  end

  assign step = ctl_i.adv && ctl_i.busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      bias_q  <= '0;
      turns_q <= '0;
      sum_q   <= '0;
    end else if (step) begin
      last_q  <= last_d;
      bias_q  <= bias_d;
      turns_q <= turns_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      count_q    <= count;
      rel_q      <= rel;
      rate_q     <= is_sample ? rate : '0;
      avg_q      <= avg_full[mtenc_pkg::RATE_W-1:0];
      turn_out_q <= turns_d;
    end
  end

  assign wr_o.we   = step && is_sample;
  assign wr_o.addr = slot_q;
  assign wr_o.data = rate;

  assign count_o = count_q;
  assign rel_o   = rel_q;
  assign rate_o  = rate_q;
  assign avg_o   = avg_q;
  assign turns_o = turn_out_q;

endmodule

FILE: hw/rtl/mtenc_scale.sv
// Angle stage: multiplies the relative count by the Q16 scale and holds
// the finished result word. Depends on mtenc_pkg.
module mtenc_scale (
  input  logic                                 clk_i,
  input  logic                                 adv_i,
  input  logic signed [mtenc_pkg::REL_W-1:0]   rel_i,
  input  logic [mtenc_pkg::SCALE_W-1:0]        scale_i,
  input  logic [mtenc_pkg::COUNT_W-1:0]        count_i,
  input  logic [mtenc_pkg::RATE_W-1:0]         rate_i,
  input  logic [mtenc_pkg::RATE_W-1:0]         avg_i,
  input  logic [mtenc_pkg::TURN_W-1:0]         turns_i,
  output logic [mtenc_pkg::COUNT_W-1:0]        count_o,
  output logic [mtenc_pkg::ANGLE_W-1:0]        angle_o,
  output logic [mtenc_pkg::RATE_W-1:0]         rate_o,
  output logic [mtenc_pkg::RATE_W-1:0]         avg_o,
  output logic [mtenc_pkg::TURN_W-1:0]         turns_o
);

  logic signed [mtenc_pkg::PROD_W-1:0] rel_ext;
  logic signed [mtenc_pkg::PROD_W-1:0] scale_ext;
  logic signed [mtenc_pkg::PROD_W-1:0] prod;
  logic [mtenc_pkg::COUNT_W-1:0]       count_q;
  logic signed [mtenc_pkg::PROD_W-1:0] prod_q;
  logic [mtenc_pkg::RATE_W-1:0]        rate_q;
  logic [mtenc_pkg::RATE_W-1:0]        avg_q;
  logic [mtenc_pkg::TURN_W-1:0]        turns_q;

  assign rel_ext   = {{(mtenc_pkg::PROD_W-mtenc_pkg::REL_W){rel_i[mtenc_pkg::REL_W-1]}},
                      rel_i};
  assign scale_ext = {{(mtenc_pkg::PROD_W-mtenc_pkg::SCALE_W){1'b0}}, scale_i};
  assign prod      = rel_ext * scale_ext;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      count_q <= count_i;
      prod_q  <= prod;
      rate_q  <= rate_i;
      avg_q   <= avg_i;
      turns_q <= turns_i;
    end
  end

  assign count_o = count_q;
  assign angle_o = {{(mtenc_pkg::ANGLE_W-mtenc_pkg::PROD_W){prod_q[mtenc_pkg::PROD_W-1]}},
                    prod_q};
  assign rate_o  = rate_q;
  assign avg_o   = avg_q;
  assign turns_o = turns_q;

endmodule

FILE: hw/rtl/mtenc_chk.sv
// Port-level checker for the multiturn encoder unwrapper, bound to the top.
// Depends on mtenc_pkg for field widths.
module mtenc_chk (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [mtenc_pkg::COUNT_W-1:0] continuous_count_o,
  input logic signed [mtenc_pkg::RATE_W-1:0]  step_rate_o,
  input logic signed [mtenc_pkg::TURN_W-1:0]  turns_o
);

  // a stalled result word stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free output");

  // count upper bits are the turn counter
  a_count_turns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> continuous_count_o[mtenc_pkg::COUNT_W-1:mtenc_pkg::READ_W] == turns_o)
    else $error("count and turns disagree");

  // unwrapped step stays within half a revolution
  a_rate_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> step_rate_o >= -$signed(mtenc_pkg::RATE_W'(mtenc_pkg::HALF_REV))
                 && step_rate_o <= $signed(mtenc_pkg::RATE_W'(mtenc_pkg::HALF_REV)))
    else $error("step rate out of range");

  // turn counter saturates short of the most negative code
  a_turn_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> turns_o != {1'b1, {(mtenc_pkg::TURN_W-1){1'b0}}})
    else $error("turn counter passed its limit");

endmodule

bind multiturn_encoder_unwrap_rate_avg_core mtenc_chk u_mtenc_chk (.*);
